// ----- sv/hkvt_pkg.sv -----
package hkvt_pkg;

  // Table geometry
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Hash seed
  localparam logic [31:0] HASH_SEED = 32'd5381;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_CREATE = 2'd1,
    FUNC_UPDATE = 2'd2,
    FUNC_INCR   = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_FULL        = 3'd1,
    STAT_DENIED      = 3'd2,
    STAT_NOT_FOUND   = 3'd3,
    STAT_UNSUPPORTED = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_RESOLVE
  } state_t;

  // One table entry as held in the memory
  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] value;
    logic [31:0] owner;
    logic        read_only;
    logic        is_float;
  } entry_t;

endpackage

// ----- sv/hkvt_req_if.sv -----
interface hkvt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  key_char;
  logic        key_last;
  logic [31:0] value;
  logic        value_is_float;
  logic        has_owner;
  logic [31:0] owner_id;

  modport source (
    output valid, func, key_char, key_last, value, value_is_float, has_owner, owner_id,
    input  ready
  );
  modport sink (
    input  valid, func, key_char, key_last, value, value_is_float, has_owner, owner_id,
    output ready
  );
endinterface

// ----- sv/hkvt_rsp_if.sv -----
interface hkvt_rsp_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [2:0]  status;
  logic [31:0] read_value;
  logic        read_is_float;

  modport source (
    output valid, success, status, read_value, read_is_float,
    input  ready
  );
  modport sink (
    input  valid, success, status, read_value, read_is_float,
    output ready
  );
endinterface

// ----- sv/hash_keyed_value_table_core.sv -----
// Key-value table addressed by the djb2 hash of a streamed key string. Each
// request moves one key character; characters that are not the last give no
// result. On the last character the operation (read, create, update,
// increment) runs against a table memory of ENTRIES entries with one write
// port and one registered read port, scanned from index 0 with one read and
// one compare per entry; create skips the scan. The result sits in an output
// register; new key characters are taken while it waits, but the next
// operation holds in its resolve state until the register is free. Only
// entries below the fill count are ever read, so the memory needs no
// clearing pass.
module hash_keyed_value_table_core (
  input  logic            clk,
  input  logic            rst,
  hkvt_req_if.sink        req,
  hkvt_rsp_if.source      rsp
);

  hkvt_pkg::state_t                state, state_next;
  logic [31:0]                     acc, acc_next;
  logic [hkvt_pkg::CNT_W-1:0]      idx, idx_next;
  logic [hkvt_pkg::CNT_W-1:0]      count, count_next;
  logic                            found, found_next;

  // Latched operation
  logic [31:0]                     op_hash;
  hkvt_pkg::func_t                 func_q;
  logic [31:0]                     value_q;
  logic                            vfloat_q;
  logic                            owned_q;
  logic [31:0]                     owner_q;

  // Output register
  logic                            out_valid, out_valid_next;
  logic                            out_success, out_success_next;
  hkvt_pkg::status_t               out_status, out_status_next;
  logic [31:0]                     out_value, out_value_next;
  logic                            out_float, out_float_next;

  // Table memory
  hkvt_pkg::entry_t                mem [hkvt_pkg::ENTRIES];
  hkvt_pkg::entry_t                rd_q;
  logic                            mem_re, mem_we;
  logic [hkvt_pkg::IDX_W-1:0]      mem_ra, mem_wa;
  hkvt_pkg::entry_t                mem_wd;

  logic [31:0]                     hash_new;
  logic                            req_take;
  logic                            full;
  logic                            out_free;
  logic                            allowed;

  assign req.ready = (state == hkvt_pkg::ST_IDLE);
  assign req_take  = req.valid && req.ready;
  assign hash_new  = (acc << 5) + acc + 32'(req.key_char);
  assign full      = (count == hkvt_pkg::CNT_W'(hkvt_pkg::ENTRIES));
  assign out_free  = !out_valid || rsp.ready;
  assign allowed   = owned_q ? (rd_q.owner == owner_q) : !rd_q.read_only;

  assign rsp.valid         = out_valid;
  assign rsp.success       = out_success;
  assign rsp.status        = out_status;
  assign rsp.read_value    = out_value;
  assign rsp.read_is_float = out_float;

  // Hold the table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // Latch the operation fields on the last key character
  always_ff @(posedge clk) begin
    if (req_take && req.key_last) begin
      op_hash  <= hash_new;
      func_q   <= hkvt_pkg::func_t'(req.func);
      value_q  <= req.value;
      vfloat_q <= req.value_is_float;
      owned_q  <= req.has_owner;
      owner_q  <= req.owner_id;
    end
  end

  // Control and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hkvt_pkg::ST_IDLE;
      acc       <= hkvt_pkg::HASH_SEED;
      idx       <= '0;
      count     <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      acc       <= acc_next;
      idx       <= idx_next;
      count     <= count_next;
      found     <= found_next;
      out_valid <= out_valid_next;
    end
    out_success <= out_success_next;
    out_status  <= out_status_next;
    out_value   <= out_value_next;
    out_float   <= out_float_next;
  end

  // Sequence the hash, the scan and the final read-modify-write
  always_comb begin
    state_next       = state;
    acc_next         = acc;
    idx_next         = idx;
    count_next       = count;
    found_next       = found;
    out_valid_next   = out_valid && !rsp.ready;
    out_success_next = out_success;
    out_status_next  = out_status;
    out_value_next   = out_value;
    out_float_next   = out_float;
    mem_re           = 1'b0;
    mem_ra           = idx[hkvt_pkg::IDX_W-1:0];
    mem_we           = 1'b0;
    mem_wa           = idx[hkvt_pkg::IDX_W-1:0];
    mem_wd           = rd_q;

    case (state)
      hkvt_pkg::ST_IDLE: begin
        // Fold the character; on the last one start the operation
        if (req_take) begin
          if (req.key_last) begin
            acc_next   = hkvt_pkg::HASH_SEED;
            idx_next   = '0;
            found_next = 1'b0;
            if (hkvt_pkg::func_t'(req.func) == hkvt_pkg::FUNC_CREATE) begin
              state_next = hkvt_pkg::ST_RESOLVE;
            end else begin
              state_next = hkvt_pkg::ST_SCAN_RD;
            end
          end else begin
            acc_next = hash_new;
          end
        end
      end

      hkvt_pkg::ST_SCAN_RD: begin
        // Issue the read of the next filled entry, or stop at the fill count
        if (idx == count) begin
          state_next = hkvt_pkg::ST_RESOLVE;
        end else begin
          mem_re     = 1'b1;
          state_next = hkvt_pkg::ST_SCAN_CMP;
        end
      end

      hkvt_pkg::ST_SCAN_CMP: begin
        // Compare the stored hash; stop on the first match
        if (rd_q.hash == op_hash) begin
          found_next = 1'b1;
          state_next = hkvt_pkg::ST_RESOLVE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = hkvt_pkg::ST_SCAN_RD;
        end
      end

      hkvt_pkg::ST_RESOLVE: begin
        // Apply the operation once the output register can take the result
        if (out_free) begin
          state_next       = hkvt_pkg::ST_IDLE;
          out_valid_next   = 1'b1;
          out_success_next = 1'b1;
          out_status_next  = hkvt_pkg::STAT_OK;
          out_value_next   = rd_q.value;
          out_float_next   = rd_q.is_float;
          mem_wd           = rd_q;
          if (!found && func_q == hkvt_pkg::FUNC_READ) begin
            out_success_next = 1'b0;
            out_status_next  = hkvt_pkg::STAT_NOT_FOUND;
            out_value_next   = '0;
            out_float_next   = 1'b0;
          end else if (!found || func_q == hkvt_pkg::FUNC_CREATE) begin
            // Append at the fill count
            mem_wa = count[hkvt_pkg::IDX_W-1:0];
            if (full) begin
              out_success_next = 1'b0;
              out_status_next  = hkvt_pkg::STAT_FULL;
              out_value_next   = '0;
              out_float_next   = 1'b0;
            end else if (func_q == hkvt_pkg::FUNC_INCR) begin
              mem_we           = 1'b1;
              count_next       = count + 1'b1;
              mem_wd.hash      = op_hash;
              mem_wd.value     = 32'd1;
              mem_wd.owner     = '0;
              mem_wd.read_only = 1'b0;
              mem_wd.is_float  = 1'b0;
              out_value_next   = 32'd1;
              out_float_next   = 1'b0;
            end else begin
              mem_we           = 1'b1;
              count_next       = count + 1'b1;
              mem_wd.hash      = op_hash;
              mem_wd.value     = value_q;
              mem_wd.owner     = owned_q ? owner_q : '0;
              mem_wd.read_only = owned_q;
              mem_wd.is_float  = vfloat_q;
              out_value_next   = value_q;
              out_float_next   = vfloat_q;
            end
          end else if (func_q == hkvt_pkg::FUNC_UPDATE) begin
            if (allowed && rd_q.is_float == vfloat_q) begin
              mem_we         = 1'b1;
              mem_wd.value   = value_q;
              out_value_next = value_q;
            end else begin
              out_success_next = 1'b0;
              out_status_next  = hkvt_pkg::STAT_DENIED;
            end
          end else if (func_q == hkvt_pkg::FUNC_INCR) begin
            if (rd_q.is_float) begin
              out_success_next = 1'b0;
              out_status_next  = hkvt_pkg::STAT_UNSUPPORTED;
            end else begin
              mem_we         = 1'b1;
              mem_wd.value   = rd_q.value + 32'd1;
              out_value_next = rd_q.value + 32'd1;
            end
          end
        end
      end

      default: begin
        state_next = hkvt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- bench/tb_hash_keyed_value_table_core.sv -----
`timescale 1ns / 1ps

module tb_hash_keyed_value_table_core;

  localparam int ITEMS       = 1500;
  localparam int KEY_POOL    = 40;
  localparam int HOLD_AT     = 800;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 300;

  typedef struct {
    hkvt_pkg::func_t func;
    logic [7:0]      key_char;
    logic            key_last;
    logic [31:0]     value;
    logic            value_is_float;
    logic            has_owner;
    logic [31:0]     owner_id;
    bit              drain;
  } key_req_t;

  typedef struct {
    logic              success;
    hkvt_pkg::status_t status;
    logic [31:0]       value;
    logic              is_float;
  } table_reply_t;

  logic clk;
  logic rst;

  hkvt_req_if req_bus ();
  hkvt_rsp_if rsp_bus ();

  hash_keyed_value_table_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Shadow copy of the table
  logic [31:0] key_acc;
  int          slot_count;
  logic [31:0] slot_hash  [hkvt_pkg::ENTRIES];
  logic [31:0] slot_value [hkvt_pkg::ENTRIES];
  logic [31:0] slot_owner [hkvt_pkg::ENTRIES];
  logic        slot_locked[hkvt_pkg::ENTRIES];
  logic        slot_float [hkvt_pkg::ENTRIES];

  key_req_t     work_q[$];
  table_reply_t due_replies[$];
  key_req_t     cur_req;
  table_reply_t want;

  int n_queued;
  int n_req_accepted;
  int n_errors;
  bit offering;
  int burst_left;
  int gap_left;
  int hold_left;
  bit hold_done;
  int rx_mode;
  int mode_left;
  int idle_cycles;

  logic [31:0] pool_bytes[KEY_POOL];
  int          pool_len  [KEY_POOL];
  logic [31:0] owner_pool[4];

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Append an entry; returns its index, or -1 when the table is full
  function automatic int append_slot(input logic [31:0] h, input logic [31:0] v,
                                     input logic vf, input logic ho,
                                     input logic [31:0] oid);
    int n;
    n = slot_count;
    if (n >= hkvt_pkg::ENTRIES) return -1;
    slot_hash[n]   = h;
    slot_value[n]  = v;
    slot_float[n]  = vf;
    slot_owner[n]  = ho ? oid : 32'd0;
    slot_locked[n] = ho;
    slot_count     = n + 1;
    return n;
  endfunction

  // Fold one key character; on the last one run the operation and queue its reply
  function automatic void predict_table_reply(input key_req_t r);
    logic [31:0]       h;
    int                idx;
    hkvt_pkg::status_t st;
    bit                allowed;
    table_reply_t      rep;
    h = (key_acc << 5) + key_acc + {24'd0, r.key_char};
    if (!r.key_last) begin
      key_acc = h;
      return;
    end
    key_acc = hkvt_pkg::HASH_SEED;
    st  = hkvt_pkg::STAT_OK;
    idx = -1;
    if (r.func != hkvt_pkg::FUNC_CREATE) begin
      for (int i = 0; i < slot_count; i++) begin
        if (idx < 0 && slot_hash[i] == h) idx = i;
      end
    end
    case (r.func)
      hkvt_pkg::FUNC_READ: begin
        if (idx < 0) st = hkvt_pkg::STAT_NOT_FOUND;
      end
      hkvt_pkg::FUNC_CREATE: begin
        idx = append_slot(h, r.value, r.value_is_float, r.has_owner, r.owner_id);
        if (idx < 0) st = hkvt_pkg::STAT_FULL;
      end
      hkvt_pkg::FUNC_UPDATE: begin
        if (idx < 0) begin
          idx = append_slot(h, r.value, r.value_is_float, r.has_owner, r.owner_id);
          if (idx < 0) st = hkvt_pkg::STAT_FULL;
        end else begin
          allowed = r.has_owner ? (slot_owner[idx] == r.owner_id) : !slot_locked[idx];
          if (allowed && slot_float[idx] == r.value_is_float) slot_value[idx] = r.value;
          else st = hkvt_pkg::STAT_DENIED;
        end
      end
      default: begin
        if (idx < 0) idx = append_slot(h, 32'd0, 1'b0, 1'b0, 32'd0);
        if (idx < 0) st = hkvt_pkg::STAT_FULL;
        else if (slot_float[idx]) st = hkvt_pkg::STAT_UNSUPPORTED;
        else slot_value[idx] = slot_value[idx] + 32'd1;
      end
    endcase
    rep.success  = (st == hkvt_pkg::STAT_OK);
    rep.status   = st;
    rep.value    = (idx >= 0) ? slot_value[idx] : 32'd0;
    rep.is_float = (idx >= 0) ? slot_float[idx] : 1'b0;
    due_replies.push_back(rep);
  endfunction

  function automatic logic [7:0] random_key_char();
    if ($urandom_range(0, 29) == 0) return 8'd0;
    return 8'($urandom_range(1, 255));
  endfunction

  // Queue one operation as a string of key characters; fields of the
  // non-final characters are noise
  task automatic queue_op(input logic [31:0] kb, input int klen, input hkvt_pkg::func_t f,
                          input logic [31:0] v, input logic vf, input logic ho,
                          input logic [31:0] oid, input bit drain);
    key_req_t it;
    for (int i = 0; i < klen; i++) begin
      it.key_char = kb[8*i +: 8];
      it.key_last = (i == klen - 1);
      it.drain    = drain && (i == 0);
      if (it.key_last) begin
        it.func           = f;
        it.value          = v;
        it.value_is_float = vf;
        it.has_owner      = ho;
        it.owner_id       = oid;
      end else begin
        it.func           = hkvt_pkg::func_t'($urandom_range(0, 3));
        it.value          = $urandom;
        it.value_is_float = 1'($urandom_range(0, 1));
        it.has_owner      = 1'($urandom_range(0, 1));
        it.owner_id       = $urandom;
      end
      work_q.push_back(it);
      n_queued++;
    end
  endtask

  // Request driver: bursts of requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
      offering   = 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        predict_table_reply(cur_req);
        n_req_accepted++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (work_q.size() != 0 &&
                     !(work_q[0].drain && due_replies.size() != 0)) begin
          cur_req  = work_q.pop_front();
          offering = 1'b1;
          req_bus.func           <= cur_req.func;
          req_bus.key_char       <= cur_req.key_char;
          req_bus.key_last       <= cur_req.key_last;
          req_bus.value          <= cur_req.value;
          req_bus.value_is_float <= cur_req.value_is_float;
          req_bus.has_owner      <= cur_req.has_owner;
          req_bus.owner_id       <= cur_req.owner_id;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
      req_bus.valid <= offering;
    end
  end

  // Reply sink: stall pattern in modes, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      rx_mode   = 0;
      mode_left = 0;
    end else begin
      if (!hold_done && n_req_accepted >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 120);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
          default: rsp_bus.ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // Reply monitor: compare against the oldest expected reply
  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (due_replies.size() == 0) begin
        $error("reply with none expected: success %0d status %0d value %h float %0d",
               rsp_bus.success, rsp_bus.status, rsp_bus.read_value, rsp_bus.read_is_float);
        n_errors++;
      end else begin
        want = due_replies.pop_front();
        if (rsp_bus.success !== want.success) begin
          $error("success: expected %0d, actual %0d", want.success, rsp_bus.success);
          n_errors++;
        end
        if (rsp_bus.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
          n_errors++;
        end
        if (rsp_bus.read_value !== want.value) begin
          $error("read_value: expected %h, actual %h", want.value, rsp_bus.read_value);
          n_errors++;
        end
        if (rsp_bus.read_is_float !== want.is_float) begin
          $error("read_is_float: expected %0d, actual %0d", want.is_float,
                 rsp_bus.read_is_float);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    int              k;
    int              klen;
    int              pick;
    int              n_ops;
    logic [31:0]     kb;
    logic [31:0]     v;
    logic [31:0]     oid;
    hkvt_pkg::func_t f;

    rst = 1'b1;
    req_bus.valid          = 1'b0;
    req_bus.func           = hkvt_pkg::FUNC_READ;
    req_bus.key_char       = 8'd0;
    req_bus.key_last       = 1'b0;
    req_bus.value          = 32'd0;
    req_bus.value_is_float = 1'b0;
    req_bus.has_owner      = 1'b0;
    req_bus.owner_id       = 32'd0;
    rsp_bus.ready          = 1'b0;
    key_acc        = hkvt_pkg::HASH_SEED;
    slot_count     = 0;
    n_queued       = 0;
    n_req_accepted = 0;
    n_errors       = 0;
    idle_cycles    = 0;

    // Directed: extremes, every operation and the access rules
    queue_op(32'h0000_0001, 1, hkvt_pkg::FUNC_READ,   32'h0,         1'b0, 1'b0, 32'h0, 1'b0);
    queue_op(32'h0000_00FF, 1, hkvt_pkg::FUNC_CREATE, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0);
    queue_op(32'h0000_00FF, 1, hkvt_pkg::FUNC_READ,   32'h0,         1'b0, 1'b0, 32'h0, 1'b0);
    // type mismatch is denied
    queue_op(32'h0000_00FF, 1, hkvt_pkg::FUNC_UPDATE, 32'h1234_5678, 1'b1, 1'b0, 32'h0, 1'b0);
    // owner id 0 matches an unowned entry
    queue_op(32'h0000_00FF, 1, hkvt_pkg::FUNC_UPDATE, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0, 1'b0);
    // increment wraps to zero
    queue_op(32'h0000_00FF, 1, hkvt_pkg::FUNC_INCR,   32'h0,         1'b0, 1'b0, 32'h0, 1'b0);
    // owned float entry keyed with a zero character
    queue_op(32'h0000_8000, 2, hkvt_pkg::FUNC_CREATE, 32'h3F80_0000, 1'b1, 1'b1,
             32'hA5A5_5A5A, 1'b0);
    queue_op(32'h0000_8000, 2, hkvt_pkg::FUNC_UPDATE, 32'h4000_0000, 1'b1, 1'b0, 32'h0, 1'b0);
    queue_op(32'h0000_8000, 2, hkvt_pkg::FUNC_UPDATE, 32'h4000_0000, 1'b1, 1'b1,
             32'h5A5A_A5A5, 1'b0);
    queue_op(32'h0000_8000, 2, hkvt_pkg::FUNC_UPDATE, 32'h7F7F_FFFF, 1'b1, 1'b1,
             32'hA5A5_5A5A, 1'b0);
    queue_op(32'h0000_8000, 2, hkvt_pkg::FUNC_INCR,   32'h0,         1'b0, 1'b0, 32'h0, 1'b0);
    // missing key: increment and update both create
    queue_op(32'h0043_4241, 3, hkvt_pkg::FUNC_INCR,   32'hFFFF_FFFF, 1'b1, 1'b1,
             32'hFFFF_FFFF, 1'b0);
    queue_op(32'h0000_0001, 1, hkvt_pkg::FUNC_UPDATE, 32'h8000_0001, 1'b0, 1'b0,
             32'h1234_5678, 1'b0);
    // duplicate create; read still finds the first entry
    queue_op(32'h0000_00FF, 1, hkvt_pkg::FUNC_CREATE, 32'h0000_0055, 1'b1, 1'b0, 32'h0, 1'b0);
    queue_op(32'h0000_00FF, 1, hkvt_pkg::FUNC_READ,   32'h0,         1'b0, 1'b0, 32'h0, 1'b1);

    // Random: mostly a pool of known keys, some fresh ones
    owner_pool[0] = 32'd0;
    for (int i = 1; i < 4; i++) owner_pool[i] = $urandom;
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_len[i]   = $urandom_range(1, 4);
      pool_bytes[i] = 32'd0;
      for (int j = 0; j < 4; j++) pool_bytes[i][8*j +: 8] = random_key_char();
    end
    n_ops = 0;
    while (n_queued < ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        k    = $urandom_range(0, KEY_POOL - 1);
        kb   = pool_bytes[k];
        klen = pool_len[k];
      end else begin
        klen = $urandom_range(1, 4);
        for (int j = 0; j < 4; j++) kb[8*j +: 8] = random_key_char();
      end
      pick = $urandom_range(0, 99);
      if (pick < 30)      f = hkvt_pkg::FUNC_READ;
      else if (pick < 40) f = hkvt_pkg::FUNC_CREATE;
      else if (pick < 75) f = hkvt_pkg::FUNC_UPDATE;
      else                f = hkvt_pkg::FUNC_INCR;
      pick = $urandom_range(0, 15);
      if (pick < 2)       v = 32'hFFFF_FFFF;
      else if (pick == 2) v = 32'd0;
      else                v = $urandom;
      oid = ($urandom_range(0, 9) == 0) ? $urandom : owner_pool[$urandom_range(0, 3)];
      queue_op(kb, klen, f, v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), oid,
               n_ops == 40 || n_ops == 120);
      n_ops++;
    end

    // Release reset
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Drain, then let the block settle
    @(posedge clk);
    while (work_q.size() != 0 || offering || due_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/hkvt_pkg.sv
sv/hkvt_req_if.sv
sv/hkvt_rsp_if.sv
sv/hash_keyed_value_table_core.sv
bench/tb_hash_keyed_value_table_core.sv
